// ----- src/fnds_pkg.sv -----
// Package for the fractional-N divider search block.
// Holds shared widths, parameter defaults, reset values and the sequencer state type.
// No dependencies.
`default_nettype none
package fnds_pkg;
	localparam int TARGET_W = 23;
	localparam int REF_W = 18;
	localparam int WORD_W = 12;
	localparam int N_W = 8;
	localparam int NUM_W = 27;
	localparam int DIV_W = 32;
	localparam int DVS_W = REF_W + 1;
	localparam int ERR_W = REF_W - 1;

	localparam int MOD_MAX_DEF = 4095;
	localparam int VCO_FLOOR_DEF = 3000000;
	localparam int REF_DIVIDER_DEF = 2;
	localparam logic [REF_W-1:0] REF_RESET = REF_W'(60000);
	localparam logic [N_W-1:0] N_SAT = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DBL,
		ST_NGO,
		ST_NWAIT,
		ST_MUL,
		ST_FGO,
		ST_FWAIT,
		ST_SGO,
		ST_SWAIT,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

// ----- src/fnds_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on fnds_pkg for widths.
`default_nettype none
module fnds_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [fnds_pkg::DIV_W-1:0] dividend,
	input  wire logic [fnds_pkg::DVS_W-1:0] divisor,
	output logic      [fnds_pkg::DIV_W-1:0] quotient,
	output logic      [fnds_pkg::DVS_W-1:0] remainder,
	output logic                            done
);
	localparam int CNT_W = $clog2(fnds_pkg::DIV_W);

	logic [fnds_pkg::DIV_W-1:0] quo_q;
	logic [fnds_pkg::DVS_W-1:0] rem_q;
	logic [fnds_pkg::DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [fnds_pkg::DVS_W:0]   shifted;
	logic [fnds_pkg::DVS_W:0]   diff;
	logic                       fits;

	always_comb begin
		shifted = {rem_q, quo_q[fnds_pkg::DIV_W-1]};
		diff = shifted - {1'b0, dvs_q};
		fits = shifted >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(fnds_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[fnds_pkg::DIV_W-2:0], fits};
			rem_q <= fits ? diff[fnds_pkg::DVS_W-1:0] : shifted[fnds_pkg::DVS_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign remainder = rem_q;
	assign done = done_q;
endmodule
`default_nettype wire

// ----- src/fnds_search.sv -----
// Modulus search: walks M downward one candidate per cycle, tracking the rounded
// fraction incrementally and keeping the best error. Depends on fnds_pkg.
`default_nettype none
module fnds_search #(
	parameter int MOD_MAX = fnds_pkg::MOD_MAX_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [fnds_pkg::REF_W-1:0]  rem_r,
	input  wire logic [fnds_pkg::REF_W-1:0]  ref_khz,
	input  wire logic [fnds_pkg::WORD_W-1:0] f_init,
	input  wire logic [fnds_pkg::DVS_W-1:0]  t_init,
	output logic      [fnds_pkg::WORD_W-1:0] best_f,
	output logic      [fnds_pkg::WORD_W-1:0] best_m,
	output logic                             done
);
	localparam int TW = fnds_pkg::DVS_W;
	localparam int PW = fnds_pkg::ERR_W + fnds_pkg::WORD_W;

	// t tracks 2*r*m + ref - 2*f*ref and stays in [0, 2*ref).
	logic [TW-1:0]                 t_q;
	logic [fnds_pkg::WORD_W-1:0]   m_q;
	logic [fnds_pkg::WORD_W-1:0]   f_q;
	logic [fnds_pkg::ERR_W-1:0]    best_e_q;
	logic [fnds_pkg::WORD_W-1:0]   best_f_q;
	logic [fnds_pkg::WORD_W-1:0]   best_m_q;
	logic                          have_q;
	logic                          busy_q;
	logic                          done_q;
	logic [TW:0]                   dev;
	logic [TW:0]                   dev_abs;
	logic [fnds_pkg::ERR_W-1:0]    err;
	logic [PW-1:0]                 lhs;
	logic [PW-1:0]                 rhs;
	logic                          take;
	logic                          last;
	logic [TW:0]                   t_step;
	logic [TW:0]                   t_next;

	always_comb begin
		dev = {1'b0, t_q} - {2'b0, ref_khz};
		dev_abs = dev[TW] ? (~dev + 1'b1) : dev;
		err = dev_abs[fnds_pkg::ERR_W:1];
		lhs = PW'(err) * PW'(best_m_q);
		rhs = PW'(best_e_q) * PW'(m_q);
		take = !have_q || (lhs <= rhs);
		last = (err == '0) || (m_q == fnds_pkg::WORD_W'(2));
		t_step = {1'b0, t_q} - {1'b0, rem_r, 1'b0};
		t_next = t_step[TW] ? (t_step + {1'b0, ref_khz, 1'b0}) : t_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			have_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				have_q <= 1'b0;
			end else if (busy_q) begin
				have_q <= 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			t_q <= t_init;
			f_q <= f_init;
			m_q <= fnds_pkg::WORD_W'(MOD_MAX);
		end else if (busy_q) begin
			if (take) begin
				best_e_q <= err;
				best_f_q <= f_q;
				best_m_q <= m_q;
			end
			t_q <= t_next[TW-1:0];
			f_q <= t_step[TW] ? (f_q - 1'b1) : f_q;
			m_q <= m_q - 1'b1;
		end
	end

	assign best_f = best_f_q;
	assign best_m = best_m_q;
	assign done = done_q;
endmodule
`default_nettype wire

// ----- src/frac_n_divider_search.sv -----
// Top level of the fractional-N divider search: sequencer, shared divider and search unit.
// Depends on fnds_pkg, fnds_div and fnds_search.
`default_nettype none
// One target is taken at a time; in_ready is low until its result is registered.
// An item goes through the doubling state until the target reaches the VCO floor,
// a divider pass for N, one multiply, a divider pass for the starting fraction,
// then the modulus walk, one modulus per cycle (at most MOD_MAX - 1 moduli tried).
// An exact hit ends the walk early. A zero reference skips the arithmetic: the
// sequencer goes from idle straight to the output state, and the result is
// registered there once the output register is free. The result stays on the
// output register until taken, and the next target may be accepted meanwhile.
module frac_n_divider_search #(
	parameter int MOD_MAX = fnds_pkg::MOD_MAX_DEF,
	parameter int VCO_FLOOR_KHZ = fnds_pkg::VCO_FLOOR_DEF,
	parameter int REF_DIVIDER = fnds_pkg::REF_DIVIDER_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [fnds_pkg::REF_W-1:0]    ref_clock_khz,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [fnds_pkg::TARGET_W-1:0] target_khz,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [fnds_pkg::WORD_W-1:0]   f_word,
	output logic      [fnds_pkg::WORD_W-1:0]   m_word,
	output logic      [fnds_pkg::N_W-1:0]      n_word,
	output logic                               n_overflow
);
	localparam int PRD_W = fnds_pkg::REF_W + fnds_pkg::WORD_W;

	fnds_pkg::state_t state_q, state_d;

	logic [fnds_pkg::REF_W-1:0]    ref_q;
	logic [fnds_pkg::TARGET_W-1:0] vco_q;
	logic [fnds_pkg::REF_W-1:0]    r_q;
	logic [PRD_W-1:0]              prod_q;
	logic [fnds_pkg::N_W-1:0]      n_q;
	logic                          ovf_q;
	logic                          zero_ref_q;
	logic                          out_valid_q;
	logic [fnds_pkg::WORD_W-1:0]   f_out_q;
	logic [fnds_pkg::WORD_W-1:0]   m_out_q;
	logic [fnds_pkg::N_W-1:0]      n_out_q;
	logic                          ovf_out_q;

	logic                          div_start;
	logic [fnds_pkg::DIV_W-1:0]    div_dividend;
	logic [fnds_pkg::DVS_W-1:0]    div_divisor;
	logic [fnds_pkg::DIV_W-1:0]    div_quo;
	logic [fnds_pkg::DVS_W-1:0]    div_rem;
	logic                          div_done;
	logic                          srch_start;
	logic [fnds_pkg::WORD_W-1:0]   srch_f;
	logic [fnds_pkg::WORD_W-1:0]   srch_m;
	logic                          srch_done;
	logic                          accept;
	logic                          need_dbl;
	logic                          out_free;
	logic [fnds_pkg::NUM_W-1:0]    num;

	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign need_dbl = (vco_q != '0) && (32'(vco_q) < 32'(VCO_FLOOR_KHZ));
	assign num = fnds_pkg::NUM_W'(vco_q) * fnds_pkg::NUM_W'(REF_DIVIDER);

	always_comb begin
		state_d = state_q;
		case (state_q)
			fnds_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (ref_q == '0) ? fnds_pkg::ST_OUT : fnds_pkg::ST_DBL;
				end
			end
			fnds_pkg::ST_DBL: begin
				if (!need_dbl) begin
					state_d = fnds_pkg::ST_NGO;
				end
			end
			fnds_pkg::ST_NGO: state_d = fnds_pkg::ST_NWAIT;
			fnds_pkg::ST_NWAIT: begin
				if (div_done) begin
					state_d = fnds_pkg::ST_MUL;
				end
			end
			fnds_pkg::ST_MUL: state_d = fnds_pkg::ST_FGO;
			fnds_pkg::ST_FGO: state_d = fnds_pkg::ST_FWAIT;
			fnds_pkg::ST_FWAIT: begin
				if (div_done) begin
					state_d = fnds_pkg::ST_SGO;
				end
			end
			fnds_pkg::ST_SGO: state_d = fnds_pkg::ST_SWAIT;
			fnds_pkg::ST_SWAIT: begin
				if (srch_done) begin
					state_d = fnds_pkg::ST_OUT;
				end
			end
			fnds_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = fnds_pkg::ST_IDLE;
				end
			end
			default: state_d = fnds_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		div_start = 1'b0;
		srch_start = 1'b0;
		div_dividend = fnds_pkg::DIV_W'(num);
		div_divisor = {1'b0, ref_q};
		case (state_q)
			fnds_pkg::ST_IDLE: in_ready = 1'b1;
			fnds_pkg::ST_NGO: div_start = 1'b1;
			fnds_pkg::ST_FGO: begin
				div_start = 1'b1;
				div_dividend = {prod_q, 1'b0} + fnds_pkg::DIV_W'(ref_q);
				div_divisor = {ref_q, 1'b0};
			end
			fnds_pkg::ST_SGO: srch_start = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fnds_pkg::ST_IDLE;
			ref_q <= fnds_pkg::REF_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				ref_q <= ref_clock_khz;
			end
			if (state_q == fnds_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vco_q <= target_khz;
			zero_ref_q <= (ref_q == '0);
		end else if (state_q == fnds_pkg::ST_DBL && need_dbl) begin
			vco_q <= {vco_q[fnds_pkg::TARGET_W-2:0], 1'b0};
		end
		if (state_q == fnds_pkg::ST_NWAIT && div_done) begin
			r_q <= div_rem[fnds_pkg::REF_W-1:0];
			ovf_q <= div_quo[fnds_pkg::DIV_W-1:fnds_pkg::N_W] != '0;
			n_q <= div_quo[fnds_pkg::N_W-1:0];
		end
		if (state_q == fnds_pkg::ST_MUL) begin
			prod_q <= PRD_W'(r_q) * PRD_W'(MOD_MAX);
		end
		if (state_q == fnds_pkg::ST_OUT && out_free) begin
			if (zero_ref_q) begin
				f_out_q <= '0;
				m_out_q <= fnds_pkg::WORD_W'(MOD_MAX);
				n_out_q <= fnds_pkg::N_SAT;
				ovf_out_q <= 1'b1;
			end else begin
				f_out_q <= srch_f;
				m_out_q <= srch_m;
				n_out_q <= ovf_q ? fnds_pkg::N_SAT : n_q;
				ovf_out_q <= ovf_q;
			end
		end
	end

	fnds_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (div_quo),
		.remainder (div_rem),
		.done      (div_done)
	);

	fnds_search #(
		.MOD_MAX (MOD_MAX)
	) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (srch_start),
		.rem_r   (r_q),
		.ref_khz (ref_q),
		.f_init  (div_quo[fnds_pkg::WORD_W-1:0]),
		.t_init  (div_rem),
		.best_f  (srch_f),
		.best_m  (srch_m),
		.done    (srch_done)
	);

	assign out_valid = out_valid_q;
	assign f_word = f_out_q;
	assign m_word = m_out_q;
	assign n_word = n_out_q;
	assign n_overflow = ovf_out_q;
endmodule
`default_nettype wire

// ----- src/fnds_checker.sv -----
// Port-level checker for frac_n_divider_search, attached by bind.
// Depends on fnds_pkg for widths.
`default_nettype none
module fnds_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [fnds_pkg::WORD_W-1:0] f_word,
	input wire logic [fnds_pkg::WORD_W-1:0] m_word,
	input wire logic [fnds_pkg::N_W-1:0]    n_word,
	input wire logic                        n_overflow
);
	// A stalled result keeps its modulus and fraction words until the transaction completes.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(m_word) && $stable(f_word))
		else $error("result changed while stalled");

	a_m_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> m_word >= fnds_pkg::WORD_W'(2))
		else $error("modulus below two");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && n_overflow |-> n_word == fnds_pkg::N_SAT)
		else $error("overflow without saturated N");

	// After a target is taken, in_ready is low in the following cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accepting a target");
endmodule

bind frac_n_divider_search fnds_checker u_fnds_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.f_word     (f_word),
	.m_word     (m_word),
	.n_word     (n_word),
	.n_overflow (n_overflow)
);
`default_nettype wire

// ----- bench/frac_n_divider_search_tb.sv -----
// Testbench for the fractional-N divider search block.
// Drives targets and reference settings, predicts F, M and N, and checks each result.
// Depends on fnds_pkg and frac_n_divider_search.
`timescale 1ns / 1ps
module frac_n_divider_search_tb;
	localparam int MOD_TOP = fnds_pkg::MOD_MAX_DEF;
	localparam longint FLOOR_KHZ = fnds_pkg::VCO_FLOOR_DEF;
	localparam longint PFD_DIV = fnds_pkg::REF_DIVIDER_DEF;
	localparam int IDLE_LIMIT = 40000;

	typedef struct packed {
		logic [fnds_pkg::WORD_W-1:0] f;
		logic [fnds_pkg::WORD_W-1:0] m;
		logic [fnds_pkg::N_W-1:0] n;
		logic ovf;
	} divider_word_t;

	typedef struct {
		logic [fnds_pkg::TARGET_W-1:0] target;
		bit known;
		divider_word_t word;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [fnds_pkg::REF_W-1:0] ref_clock_khz = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [fnds_pkg::TARGET_W-1:0] target_khz = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [fnds_pkg::WORD_W-1:0] f_word;
	logic [fnds_pkg::WORD_W-1:0] m_word;
	logic [fnds_pkg::N_W-1:0] n_word;
	logic n_overflow;

	logic [fnds_pkg::REF_W-1:0] ref_now;
	divider_word_t pending_words[$];
	int errors = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	frac_n_divider_search uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .ref_clock_khz(ref_clock_khz),
		.in_valid(in_valid), .in_ready(in_ready), .target_khz(target_khz),
		.out_valid(out_valid), .out_ready(out_ready), .f_word(f_word),
		.m_word(m_word), .n_word(n_word), .n_overflow(n_overflow)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic divider_word_t best_divider(logic [fnds_pkg::TARGET_W-1:0] target,
			logic [fnds_pkg::REF_W-1:0] refk);
		divider_word_t w;
		longint unsigned vco, rf, num, n_true, r, f, a, b, e, best_e, best_f, best_m;
		bit have;
		have = 0;
		best_e = 0;
		best_f = 0;
		best_m = MOD_TOP;
		rf = refk;
		vco = target;
		if (rf == 0) begin
			w.f = '0;
			w.m = fnds_pkg::WORD_W'(MOD_TOP);
			w.n = fnds_pkg::N_SAT;
			w.ovf = 1'b1;
			return w;
		end
		if (vco != 0)
			while (vco < FLOOR_KHZ) vco = vco << 1;
		num = vco * PFD_DIV;
		n_true = num / rf;
		r = num - n_true * rf;
		for (longint unsigned m = MOD_TOP; m >= 2; m--) begin
			f = (2 * r * m + rf) / (2 * rf);
			a = r * m;
			b = f * rf;
			e = (a >= b) ? a - b : b - a;
			if (e == 0) begin
				best_f = f;
				best_m = m;
				break;
			end
			if (!have || e * best_m <= best_e * m) begin
				have = 1;
				best_e = e;
				best_f = f;
				best_m = m;
			end
		end
		w.f = best_f[fnds_pkg::WORD_W-1:0];
		w.m = best_m[fnds_pkg::WORD_W-1:0];
		w.n = (n_true > 255) ? fnds_pkg::N_SAT : n_true[fnds_pkg::N_W-1:0];
		w.ovf = (n_true > 255);
		return w;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// Result checker and stall generator on the output side.
	always @(posedge clk) begin
		divider_word_t want;
		if (out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected transaction", 1, 0);
			end else begin
				want = pending_words.pop_front();
				if (f_word !== want.f) report_mismatch("f_word", f_word, want.f);
				if (m_word !== want.m) report_mismatch("m_word", m_word, want.m);
				if (n_word !== want.n) report_mismatch("n_word", n_word, want.n);
				if (n_overflow !== want.ovf)
					report_mismatch("n_overflow", n_overflow, want.ovf);
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic write_ref(logic [fnds_pkg::REF_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		ref_clock_khz <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		ref_now = v;
	endtask

	// Returns at the accepting edge; the next call drives the next target or drain() lowers valid.
	task automatic send_target(logic [fnds_pkg::TARGET_W-1:0] t, bit known,
			divider_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		target_khz <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_words.push_back(known ? w : best_divider(t, ref_now));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic logic [fnds_pkg::TARGET_W-1:0] rand_target();
		case ($urandom_range(4))
			0: return fnds_pkg::TARGET_W'($urandom_range(6000000, 1));
			1: return fnds_pkg::TARGET_W'($urandom_range(3000, 1));
			2: return fnds_pkg::TARGET_W'($urandom);
			default: return fnds_pkg::TARGET_W'($urandom_range(6000000, 3000000));
		endcase
	endfunction

	initial begin
		stim_row_t rows[$];
		logic [fnds_pkg::REF_W-1:0] refs[6];
		refs = '{18'd10000, 18'd210000, 18'd60000, 18'h3FFFF, 18'd19200, 18'd100000};
		ref_now = fnds_pkg::REF_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Zero target gives an exact hit at the top modulus with N of zero.
		rows.push_back('{target: '0, known: 1,
			word: '{'0, fnds_pkg::WORD_W'(MOD_TOP), '0, 1'b0}});
		// 3000 MHz against a 30 MHz comparison frequency divides exactly by 100.
		rows.push_back('{target: 23'd3000000, known: 1,
			word: '{'0, fnds_pkg::WORD_W'(MOD_TOP), 8'd100, 1'b0}});
		rows.push_back('{target: 23'd1, known: 0, word: '0});
		rows.push_back('{target: 23'h7FFFFF, known: 0, word: '0});
		rows.push_back('{target: 23'd6000000, known: 0, word: '0});
		rows.push_back('{target: 23'd2999999, known: 0, word: '0});
		rows.push_back('{target: 23'd3000001, known: 0, word: '0});
		rows.push_back('{target: 23'd5999999, known: 0, word: '0});
		rows.push_back('{target: 23'd4000007, known: 0, word: '0});
		foreach (rows[i]) send_target(rows[i].target, rows[i].known, rows[i].word);
		drain();

		// Zero reference saturates N without running the search.
		write_ref('0);
		send_target(23'd3500000, 1,
			'{'0, fnds_pkg::WORD_W'(MOD_TOP), fnds_pkg::N_SAT, 1'b1});
		send_target(23'h7FFFFF, 1,
			'{'0, fnds_pkg::WORD_W'(MOD_TOP), fnds_pkg::N_SAT, 1'b1});
		drain();
		// Small reference pushes N past its limit.
		write_ref(18'd10000);
		send_target(23'd5999999, 0, '0);
		send_target(23'd3333333, 0, '0);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 37 : 50) : 0;
			recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 37 : 50) : 0;
			for (int k = 0; k < 3; k++) begin
				write_ref(k == 0 ? refs[(phase * 3 + k) % 6]
					: fnds_pkg::REF_W'($urandom_range(210000, 10000)));
				for (int j = 0; j < 11; j++) send_target(rand_target(), 0, '0);
				drain();
			end
		end

		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
src/fnds_pkg.sv
src/fnds_div.sv
src/fnds_search.sv
src/frac_n_divider_search.sv
src/fnds_checker.sv
bench/frac_n_divider_search_tb.sv
